// ===== src/u2u8_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared types, constants and UTF-8 byte encoding for the UTF-16/32 to UTF-8 transcoder.
package u2u8_pkg;

	typedef enum logic [1:0] {
		FMT_U16LE = 2'd0,
		FMT_U16BE = 2'd1,
		FMT_U32LE = 2'd2,
		FMT_U32BE = 2'd3
	} fmt_t;

	typedef enum logic [1:0] {
		LEN_1 = 2'd0,
		LEN_2 = 2'd1,
		LEN_3 = 2'd2,
		LEN_4 = 2'd3
	} len_t;

	localparam logic [31:0] CP_MAX  = 32'h0010_FFFF;
	localparam logic [20:0] CP_REPL = 21'h00_FFFD;
	localparam logic [31:0] LIM_1   = 32'h0000_007F;
	localparam logic [31:0] LIM_2   = 32'h0000_07FF;
	localparam logic [31:0] LIM_3   = 32'h0000_FFFF;

	localparam int Q_DEPTH = 2;
	localparam int QPW     = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int QCW     = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		logic [20:0] cp;
		len_t        len;
	} unit_t;

	function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input len_t len,
			input logic [1:0] idx);
		logic [7:0] b;
		b = 8'h00;
		case (len)
			LEN_1: b = {1'b0, cp[6:0]};
			LEN_2: begin
				case (idx)
					2'd0:    b = {3'b110, cp[10:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			LEN_3: begin
				case (idx)
					2'd0:    b = {4'b1110, cp[15:12]};
					2'd1:    b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			default: begin
				case (idx)
					2'd0:    b = {5'b11110, cp[20:18]};
					2'd1:    b = {2'b10, cp[17:12]};
					2'd2:    b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

// ===== src/u2u8_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel interfaces for source bytes, UTF-8 bytes and the format register.
interface u2u8_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       stream_start;
	modport source(output valid, output in_byte, output stream_start, input ready);
	modport sink(input valid, input in_byte, input stream_start, output ready);
endinterface

interface u2u8_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;
	modport source(output valid, output out_byte, output out_last, input ready);
	modport sink(input valid, input out_byte, input out_last, output ready);
endinterface

interface u2u8_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] source_format;
	modport source(output valid, output source_format, input ready);
	modport sink(input valid, input source_format, output ready);
endinterface
`default_nettype wire

// ===== src/u2u8_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Front end: byte assembly into code units, range clamp and UTF-8 length classification.
module u2u8_front
	import u2u8_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	u2u8_in_if.sink   in_ch,
	u2u8_cfg_if.sink  cfg,
	input  wire logic q_full,
	output logic      push,
	output unit_t     push_unit
);

	fmt_t        fmt_q;
	logic [31:0] acc_q;
	logic [1:0]  pos_q;

	logic [31:0] acc_base;
	logic [1:0]  pos_base;
	logic [31:0] acc_nx;
	logic        complete;
	logic        accept;

	assign cfg.ready   = 1'b1;
	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && in_ch.ready;

	always_comb begin
		acc_base = in_ch.stream_start ? 32'd0 : acc_q;
		pos_base = in_ch.stream_start ? 2'd0 : pos_q;
		if (fmt_q[0]) begin
			acc_nx = {acc_base[23:0], in_ch.in_byte};
		end else begin
			acc_nx = acc_base | ({24'd0, in_ch.in_byte} << {pos_base, 3'b000});
		end
		complete = fmt_q[1] ? (pos_base == 2'd3) : (pos_base == 2'd1);
		push = accept && complete;
		if (acc_nx > CP_MAX) begin
			push_unit.cp  = CP_REPL;
			push_unit.len = LEN_3;
		end else begin
			push_unit.cp = acc_nx[20:0];
			if (acc_nx <= LIM_1) begin
				push_unit.len = LEN_1;
			end else if (acc_nx <= LIM_2) begin
				push_unit.len = LEN_2;
			end else if (acc_nx <= LIM_3) begin
				push_unit.len = LEN_3;
			end else begin
				push_unit.len = LEN_4;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_U16LE;
			acc_q <= 32'd0;
			pos_q <= 2'd0;
		end else if (cfg.valid && cfg.ready) begin
			fmt_q <= fmt_t'(cfg.source_format);
			acc_q <= 32'd0;
			pos_q <= 2'd0;
		end else if (accept) begin
			if (complete) begin
				acc_q <= 32'd0;
				pos_q <= 2'd0;
			end else begin
				acc_q <= acc_nx;
				pos_q <= pos_base + 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/u2u8_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Short unit queue between the front end and the UTF-8 byte emitter.
module u2u8_queue
	import u2u8_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire unit_t push_unit,
	input  wire logic  pop,
	output logic       full,
	output logic       head_valid,
	output unit_t      head
);

	unit_t            mem_q [Q_DEPTH];
	logic [QPW-1:0]   wr_ptr_q;
	logic [QPW-1:0]   rd_ptr_q;
	logic [QCW-1:0]   count_q;

	function automatic logic [QPW-1:0] ptr_inc(input logic [QPW-1:0] p);
		return (p == QPW'(Q_DEPTH - 1)) ? '0 : p + QPW'(1);
	endfunction

	assign full       = (count_q == QCW'(Q_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_unit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCW'(1);
				2'b01:   count_q <= count_q - QCW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("unit queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid) else $error("unit queue underflow");
`endif

endmodule
`default_nettype wire

// ===== src/u2u8_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Back end: emits the UTF-8 bytes of each queued unit through an output register.
module u2u8_back
	import u2u8_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  head_valid,
	input  wire unit_t head,
	output logic       pop,
	u2u8_out_if.source out_ch
);

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic [1:0] idx_q;
	logic       advance;
	logic       last_byte;

	assign advance   = !out_valid_q || out_ch.ready;
	assign last_byte = (idx_q == 2'(head.len));
	assign pop       = advance && head_valid && last_byte;

	assign out_ch.valid    = out_valid_q;
	assign out_ch.out_byte = out_byte_q;
	assign out_ch.out_last = out_last_q;

	always_ff @(posedge clk) begin
		if (advance && head_valid) begin
			out_byte_q <= utf8_byte(head.cp, head.len, idx_q);
			out_last_q <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else if (advance) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				idx_q <= last_byte ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

`ifndef SYNTHESIS
	a_idx_in_unit: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> idx_q <= 2'(head.len)) else $error("byte index past unit length");
	a_idx_needs_unit: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 2'd0 |-> head_valid) else $error("unit left queue mid-sequence");
`endif

endmodule
`default_nettype wire

// ===== src/utf16_utf32_to_utf8.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Top level of the UTF-16/UTF-32 to UTF-8 transcoder.
// Source bytes are taken one per cycle while the two-unit queue has room; every
// second (UTF-16) or fourth (UTF-32) byte completes a code unit, which is clamped
// to U+FFFD above U+10FFFF and queued. The emitter sends one UTF-8 byte per cycle
// while the output is ready, 1 to 4 bytes per unit; that emitter sets the sustained
// rate. Surrogates are encoded individually. A format write clears any partial unit.
module utf16_utf32_to_utf8
	import u2u8_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	u2u8_in_if.sink   in_ch,
	u2u8_out_if.source out_ch,
	u2u8_cfg_if.sink  cfg
);

	logic  q_full;
	logic  push;
	unit_t push_unit;
	logic  pop;
	logic  head_valid;
	unit_t head;

	u2u8_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cfg       (cfg),
		.q_full    (q_full),
		.push      (push),
		.push_unit (push_unit)
	);

	u2u8_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_unit  (push_unit),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	u2u8_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_ch     (out_ch)
	);

endmodule
`default_nettype wire
